@@ design/fdos_pkg.sv @@
// Shared constants, opcodes and controller/datapath interface types of the outcome scoreboard.
package fdos_pkg;

    localparam int FD_BITS      = 256;
    localparam int SAMPLE_TRIES = 8;
    localparam int MAP_BYTES    = FD_BITS / 8;
    localparam int MAP_AW       = $clog2(MAP_BYTES);
    localparam int FD_W         = $clog2(FD_BITS);
    localparam int PICK_STEPS   = SAMPLE_TRIES + MAP_BYTES;
    localparam int STEP_W       = $clog2(PICK_STEPS);

    localparam int OP_W  = 3;
    localparam int ARG_W = 32;
    localparam int RND_W = 64;
    localparam int PICK_W = 9;
    localparam int THR_W = 8;

    localparam logic [OP_W-1:0] OP_LENGTH  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUCCESS = 3'd1;
    localparam logic [OP_W-1:0] OP_FAILURE = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd3;
    localparam logic [OP_W-1:0] OP_PICK    = 3'd4;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd3;
    localparam logic [7:0]       RUN_COUNT_MAX   = 8'hFF;
    localparam int               FIRST_PICK_FD   = 3;

    typedef struct packed {
        logic              load;         // latch the accepted request
        logic              length_upd;   // widen the length range
        logic              rd_en;        // read one byte of both maps
        logic              rd_from_arg;  // address from descriptor, else from pick step
        logic [STEP_W-1:0] rd_step;      // pick step whose byte is read
        logic              rmw;          // write back success/failure, latch query
        logic              pick_eval;    // evaluate the byte read last cycle
        logic              out_load;     // move result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pick_hit;
    } dp_stat_t;

endpackage

@@ design/fdos_ctl.sv @@
// Sequencing state machine of the outcome scoreboard.
module fdos_ctl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  fdos_pkg::dp_stat_t stat,
    output fdos_pkg::dp_cmd_t  cmd
);
    import fdos_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_RMW    = 3'd2;
    localparam logic [2:0] S_PICK   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_LENGTH:
                    begin
                        cmd.length_upd = 1'b1;
                        state_next     = S_FINISH;
                    end
                    OP_SUCCESS, OP_FAILURE, OP_QUERY:
                    begin
                        cmd.rd_en       = 1'b1;
                        cmd.rd_from_arg = 1'b1;
                        state_next      = S_RMW;
                    end
                    OP_PICK:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_step = '0;
                        step_next  = '0;
                        state_next = S_PICK;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_RMW:
            begin
                cmd.rmw    = 1'b1;
                state_next = S_FINISH;
            end
            S_PICK:
            begin
                // evaluate step_reg while fetching the byte of the next step
                cmd.pick_eval = 1'b1;
                if (stat.pick_hit || step_reg == STEP_W'(PICK_STEPS - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_step = step_reg + STEP_W'(1);
                    step_next   = step_reg + STEP_W'(1);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/fdos_dp.sv @@
// Datapath of the outcome scoreboard: bitmaps, run tracker, length range and result registers.
module fdos_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fdos_pkg::dp_cmd_t             cmd,
    output fdos_pkg::dp_stat_t            stat,
    input  logic [fdos_pkg::OP_W-1:0]     opcode,
    input  logic [fdos_pkg::ARG_W-1:0]    argument,
    input  logic [fdos_pkg::RND_W-1:0]    random_bits,
    input  logic                          cfg_we,
    input  logic [fdos_pkg::THR_W-1:0]    cfg_data,
    output logic signed [fdos_pkg::PICK_W-1:0] picked_fd,
    output logic                          fd_failed,
    output logic [fdos_pkg::ARG_W-1:0]    length_low,
    output logic [fdos_pkg::ARG_W-1:0]    length_high,
    output logic                          length_seen
);
    import fdos_pkg::*;

    logic [OP_W-1:0]   op_reg;
    logic [ARG_W-1:0]  arg_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [ARG_W-1:0]  range_low_reg;
    logic [ARG_W-1:0]  range_high_reg;
    logic [7:0]        run_desc_reg;
    logic [7:0]        run_cnt_reg;

    logic [7:0]        success_mem [MAP_BYTES];
    logic [7:0]        failed_mem  [MAP_BYTES];
    logic [MAP_BYTES-1:0] s_vld_reg;
    logic [MAP_BYTES-1:0] f_vld_reg;
    logic [7:0]        rd_s_reg;
    logic [7:0]        rd_f_reg;
    logic [MAP_AW-1:0] rd_addr_reg;
    logic [STEP_W-1:0] rd_step_reg;

    logic signed [PICK_W-1:0] pick_res_reg;
    logic              query_reg;

    // read address
    logic [7:0]           rd_samp_byte;
    logic [MAP_AW+4:0]    rd_samp_wide;
    logic [STEP_W-1:0]    rd_scan_idx;
    logic [MAP_AW-1:0]    rd_addr;

    // range
    logic              range_unseen;
    logic [ARG_W-1:0]  range_low_next;
    logic [ARG_W-1:0]  range_high_next;

    // read-modify-write
    logic              arg_valid;
    logic [MAP_AW-1:0] arg_idx;
    logic [7:0]        arg_mask;
    logic              run_match;
    logic [7:0]        run_desc_next;
    logic [7:0]        run_cnt_next;
    logic              s_we;
    logic              f_we;
    logic [7:0]        s_wdata;
    logic [7:0]        f_wdata;
    logic              run_we;

    // pick evaluation
    logic              is_sample;
    logic [7:0]        ev_samp_byte;
    logic [2:0]        ev_rot;
    logic [15:0]       ev_dbl;
    logic [7:0]        ev_cand;
    logic [2:0]        ev_pos;
    logic [2:0]        ev_bit;
    logic [FD_W-1:0]   ev_fd;
    logic              ev_hit;

    assign rd_samp_byte = rnd_reg[{cmd.rd_step[2:0], 3'b000} +: 8];
    assign rd_samp_wide = {{MAP_AW{1'b0}}, rd_samp_byte[4:0]};
    assign rd_scan_idx  = cmd.rd_step - STEP_W'(SAMPLE_TRIES);

    always_comb
    begin
        if (cmd.rd_from_arg)
        begin
            rd_addr = arg_idx;
        end
        else if (cmd.rd_step < STEP_W'(SAMPLE_TRIES))
        begin
            rd_addr = rd_samp_wide[MAP_AW-1:0];
        end
        else
        begin
            rd_addr = rd_scan_idx[MAP_AW-1:0];
        end
    end

    assign range_unseen = (range_low_reg == '1) && (range_high_reg == '0);

    always_comb
    begin
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        if (range_unseen)
        begin
            range_low_next  = arg_reg;
            range_high_next = arg_reg;
        end
        else
        begin
            if (arg_reg < range_low_reg)
            begin
                range_low_next = arg_reg;
            end
            if (arg_reg > range_high_reg)
            begin
                range_high_next = arg_reg;
            end
        end
    end

    assign arg_valid = arg_reg < ARG_W'(FD_BITS);
    assign arg_idx   = arg_reg[FD_W-1:3];
    assign arg_mask  = 8'd1 << arg_reg[2:0];
    assign run_match = run_desc_reg == arg_reg[7:0];

    always_comb
    begin
        s_we          = 1'b0;
        f_we          = 1'b0;
        run_we        = 1'b0;
        s_wdata       = rd_s_reg | arg_mask;
        f_wdata       = rd_f_reg & ~arg_mask;
        run_desc_next = run_desc_reg;
        run_cnt_next  = run_cnt_reg;
        if (cmd.rmw && arg_valid)
        begin
            case (op_reg)
                OP_SUCCESS:
                begin
                    s_we = 1'b1;
                    f_we = 1'b1;
                    if (run_match && run_cnt_reg != 8'd0)
                    begin
                        run_we        = 1'b1;
                        run_desc_next = '0;
                        run_cnt_next  = '0;
                    end
                end
                OP_FAILURE:
                begin
                    if (arg_reg >= ARG_W'(FIRST_PICK_FD))
                    begin
                        run_we = 1'b1;
                        if (run_cnt_reg != 8'd0 && run_match)
                        begin
                            if (run_cnt_reg != RUN_COUNT_MAX)
                            begin
                                run_cnt_next = run_cnt_reg + 8'd1;
                            end
                        end
                        else
                        begin
                            run_desc_next = arg_reg[7:0];
                            run_cnt_next  = 8'd1;
                        end
                        f_wdata = rd_f_reg | arg_mask;
                        f_we    = run_cnt_next >= thr_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // pick: a sample takes the first set bit at or after its rotation, wrapping
    assign is_sample    = rd_step_reg < STEP_W'(SAMPLE_TRIES);
    assign ev_samp_byte = rnd_reg[{rd_step_reg[2:0], 3'b000} +: 8];
    assign ev_rot       = ev_samp_byte[7:5];
    assign ev_dbl       = {rd_s_reg, rd_s_reg} >> ev_rot;

    always_comb
    begin
        if (is_sample)
        begin
            ev_cand = ev_dbl[7:0];
        end
        else if (rd_addr_reg == '0)
        begin
            ev_cand = rd_s_reg & (8'hFF << FIRST_PICK_FD);
        end
        else
        begin
            ev_cand = rd_s_reg;
        end
    end

    always_comb
    begin
        ev_pos = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (ev_cand[i])
            begin
                ev_pos = 3'(i);
            end
        end
    end

    assign ev_bit = is_sample ? ev_pos + ev_rot : ev_pos;
    assign ev_fd  = {rd_addr_reg, ev_bit};
    assign ev_hit = (ev_cand != 8'd0) && (ev_fd >= FD_W'(FIRST_PICK_FD));

    assign stat.op       = op_reg;
    assign stat.pick_hit = ev_hit;

    // memories: registered read, one write port each
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_s_reg <= s_vld_reg[rd_addr] ? success_mem[rd_addr] : 8'd0;
            rd_f_reg <= f_vld_reg[rd_addr] ? failed_mem[rd_addr] : 8'd0;
        end
        if (s_we)
        begin
            success_mem[arg_idx] <= s_wdata;
        end
        if (f_we)
        begin
            failed_mem[arg_idx] <= f_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            arg_reg <= argument;
            rnd_reg <= random_bits;
        end
        if (cmd.rd_en)
        begin
            rd_addr_reg <= rd_addr;
            rd_step_reg <= cmd.rd_step;
        end
        if (cmd.load)
        begin
            pick_res_reg <= '1;
            query_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.pick_eval && ev_hit)
            begin
                pick_res_reg <= PICK_W'(ev_fd);
            end
            if (cmd.rmw && op_reg == OP_QUERY)
            begin
                query_reg <= arg_valid && rd_f_reg[arg_reg[2:0]];
            end
        end
        if (cmd.out_load)
        begin
            picked_fd   <= pick_res_reg;
            fd_failed   <= query_reg;
            length_low  <= range_low_reg;
            length_high <= range_high_reg;
            length_seen <= !range_unseen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THRESHOLD_RESET;
            range_low_reg  <= '1;
            range_high_reg <= '0;
            run_desc_reg   <= '0;
            run_cnt_reg    <= '0;
            s_vld_reg      <= '0;
            f_vld_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            if (cmd.length_upd)
            begin
                range_low_reg  <= range_low_next;
                range_high_reg <= range_high_next;
            end
            if (run_we)
            begin
                run_desc_reg <= run_desc_next;
                run_cnt_reg  <= run_cnt_next;
            end
            if (s_we)
            begin
                s_vld_reg[arg_idx] <= 1'b1;
            end
            if (f_we)
            begin
                f_vld_reg[arg_idx] <= 1'b1;
            end
        end
    end

endmodule

@@ design/fd_outcome_scoreboard_core.sv @@
// Top level of the descriptor outcome scoreboard.
//
// Requests arrive on the in_* valid/ready channel: opcode, argument and
// random_bits. Each request yields exactly one result on the out_* channel:
// picked_fd, fd_failed and the length range after the request.
// The threshold register is written through cfg_valid/cfg_data, which is
// always ready; write it only while no request is in flight.
// One request is worked at a time. From acceptance to result valid:
//   record length and unknown opcodes: decode state, then finish state;
//   success, failure and query: decode, then one read-modify-write state
//   on one byte of the maps (query only reads), then finish;
//   pick: one map byte read per cycle until a hit or the last step,
//   random samples first, then a byte-wise scan; then finish.
// A result sits in the output register until taken; the next request is
// accepted meanwhile and its result waits if the receiver stalls.
// Reset empties both maps, the run tracker and the length range, and sets
// the threshold to 3; the block accepts requests right after reset.
module fd_outcome_scoreboard_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fdos_pkg::OP_W-1:0]     opcode,
    input  logic [fdos_pkg::ARG_W-1:0]    argument,
    input  logic [fdos_pkg::RND_W-1:0]    random_bits,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [fdos_pkg::PICK_W-1:0] picked_fd,
    output logic                          fd_failed,
    output logic [fdos_pkg::ARG_W-1:0]    length_low,
    output logic [fdos_pkg::ARG_W-1:0]    length_high,
    output logic                          length_seen,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fdos_pkg::THR_W-1:0]    cfg_data
);
    import fdos_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    fdos_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fdos_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .argument    (argument),
        .random_bits (random_bits),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .picked_fd   (picked_fd),
        .fd_failed   (fd_failed),
        .length_low  (length_low),
        .length_high (length_high),
        .length_seen (length_seen)
    );

endmodule
